// ===== rtl/core/srmpu_pkg.sv =====
`default_nettype none

package srmpu_pkg;

    // register window, fixed in the address map
    localparam logic [15:0] WIN_BASE = 16'hFE00;
    localparam int unsigned WIN_SIZE = 16;
    localparam logic [15:0] WIN_LAST = 16'(WIN_BASE + WIN_SIZE - 1);

    // permission bits
    localparam logic [2:0] PR_READ  = 3'b001;
    localparam logic [2:0] PR_WRITE = 3'b010;
    localparam logic [2:0] PR_EXEC  = 3'b100;
    localparam logic [2:0] PR_ALL   = PR_READ | PR_WRITE | PR_EXEC;

    // control register bits
    localparam int unsigned CTL_EN_BIT  = 0;
    localparam int unsigned CTL_IRQ_BIT = 1;

    // register offsets
    localparam logic [3:0] OFF_CTRL     = 4'd0;
    localparam logic [3:0] OFF_START_LO = 4'd1;
    localparam logic [3:0] OFF_START_HI = 4'd2;
    localparam logic [3:0] OFF_END_LO   = 4'd3;
    localparam logic [3:0] OFF_END_HI   = 4'd4;
    localparam logic [3:0] OFF_PERMS    = 4'd5;
    localparam logic [3:0] OFF_VADDR_LO = 4'd10;
    localparam logic [3:0] OFF_VADDR_HI = 4'd11;
    localparam logic [3:0] OFF_VKIND    = 4'd12;
    localparam logic [3:0] OFF_CLEAR    = 4'd13;

    // actions
    typedef enum logic [1:0] {
        ACT_REG_READ  = 2'd0,
        ACT_REG_WRITE = 2'd1,
        ACT_CHECK     = 2'd2
    } t_action;

    // access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;

    // fault codes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_READ  = 2'd1;
    localparam logic [1:0] FLT_WRITE = 2'd2;
    localparam logic [1:0] FLT_FETCH = 2'd3;

    // one input item
    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  reg_offset;
        logic [7:0]  write_data;
        logic [15:0] address;
        logic [1:0]  access_kind;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       access_ok;
        logic [1:0] fault_kind;
        logic [2:0] granted_perms;
        logic       window_hit;
        logic       irq_out;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/single_region_memory_protection_unit.sv =====
// Single-region memory protection unit.
// Input stream (s_axis): one transfer per item. tuser carries the action
// (register read, register write, access check) and the access kind;
// tdata carries the register offset, the write byte and the address.
// Output stream (m_axis): exactly one result transfer per input item, in
// order. tdata carries the read byte, the pass flag, the granted
// permissions, the window-hit flag and the interrupt level; tuser carries
// the fault kind.
// The item is held in the input register and its result is loaded into the
// result register once that register has room; the result transfer is made
// from the result register. Throughput is one item per cycle while the
// receiver accepts every result; the check and the register update share a
// single level of logic between the two registers, so each item sees the
// state left by the one before it. Reset clears the core registers, the
// interrupt level and both valid flags, but not the payload registers.
// When the receiver stalls, the result register holds its item, the input
// register fills, and s_axis_tready drops until the result is taken.
`default_nettype none

module single_region_memory_protection_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] reg_offset, [11:4] write_data, [27:12] address, [31:28] zero
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] action, [3:2] access_kind
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_data, [8] access_ok, [11:9] granted_perms, [12] window_hit,
    // [13] irq_out, [15:14] zero
    output logic [15:0]      m_axis_tdata,
    // [1:0] fault_kind
    output logic [1:0]       m_axis_tuser
);

    srmpu_pkg::t_item   w_in_item;
    srmpu_pkg::t_item   w_cur_item;
    srmpu_pkg::t_result w_result;
    srmpu_pkg::t_result w_out_result;
    logic               w_cur_valid;
    logic               w_out_ready;
    logic               w_fire;

    // unpack the input transfer
    assign w_in_item.action      = s_axis_tuser[1:0];
    assign w_in_item.access_kind = s_axis_tuser[3:2];
    assign w_in_item.reg_offset  = s_axis_tdata[3:0];
    assign w_in_item.write_data  = s_axis_tdata[11:4];
    assign w_in_item.address     = s_axis_tdata[27:12];

    srmpu_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_out_ready),
        .o_valid   (w_cur_valid),
        .o_item    (w_cur_item)
    );

    // the held item is processed when the result register can take it
    assign w_fire = w_cur_valid && w_out_ready;

    srmpu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_cur_item),
        .o_result (w_result)
    );

    srmpu_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_cur_valid),
        .o_ready  (w_out_ready),
        .i_result (w_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out_result)
    );

    // pack the result transfer
    assign m_axis_tdata = {2'b00,
                           w_out_result.irq_out,
                           w_out_result.window_hit,
                           w_out_result.granted_perms,
                           w_out_result.access_ok,
                           w_out_result.read_data};
    assign m_axis_tuser = w_out_result.fault_kind;

endmodule

`default_nettype wire

// ===== rtl/core/srmpu_in_stage.sv =====
`default_nettype none

module srmpu_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire srmpu_pkg::t_item i_item,
    input  wire logic           i_advance,
    output logic                o_valid,
    output srmpu_pkg::t_item    o_item
);

    logic             r_valid;
    srmpu_pkg::t_item r_item;
    logic             w_load;

    // the stage takes a new transfer when empty or when its item moves on
    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/srmpu_core.sv =====
`default_nettype none

module srmpu_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire srmpu_pkg::t_item i_item,
    output srmpu_pkg::t_result    o_result
);

    logic [7:0]  r_ctrl;
    logic [15:0] r_start;
    logic [15:0] r_end;
    logic [7:0]  r_perms;
    logic [15:0] r_vaddr;
    logic [1:0]  r_vkind;
    logic        r_irq;

    logic [7:0]  n_ctrl;
    logic [15:0] n_start;
    logic [15:0] n_end;
    logic [7:0]  n_perms;
    logic [15:0] n_vaddr;
    logic [1:0]  n_vkind;
    logic        n_irq;

    logic        w_win_hit;
    logic        w_in_region;
    logic [2:0]  w_rperms;
    logic [1:0]  w_fault;
    logic [7:0]  w_rdata;

    // address decode
    assign w_win_hit = (i_item.address >= srmpu_pkg::WIN_BASE)
                    && (i_item.address <= srmpu_pkg::WIN_LAST);
    assign w_in_region = r_ctrl[srmpu_pkg::CTL_EN_BIT]
                      && (i_item.address >= r_start)
                      && (i_item.address <= r_end);
    assign w_rperms = r_perms[2:0];

    // permission check inside the region
    always_comb begin
        w_fault = srmpu_pkg::FLT_NONE;
        case (i_item.access_kind)
            srmpu_pkg::KIND_FETCH: begin
                if ((w_rperms & srmpu_pkg::PR_EXEC) == 3'b000) w_fault = srmpu_pkg::FLT_FETCH;
            end
            srmpu_pkg::KIND_READ: begin
                if ((w_rperms & srmpu_pkg::PR_READ) == 3'b000) w_fault = srmpu_pkg::FLT_READ;
            end
            srmpu_pkg::KIND_WRITE: begin
                if ((w_rperms & srmpu_pkg::PR_WRITE) == 3'b000) w_fault = srmpu_pkg::FLT_WRITE;
            end
            default: begin
                w_fault = srmpu_pkg::FLT_NONE;
            end
        endcase
    end

    // register read mux
    always_comb begin
        case (i_item.reg_offset)
            srmpu_pkg::OFF_CTRL:     w_rdata = r_ctrl;
            srmpu_pkg::OFF_START_LO: w_rdata = r_start[7:0];
            srmpu_pkg::OFF_START_HI: w_rdata = r_start[15:8];
            srmpu_pkg::OFF_END_LO:   w_rdata = r_end[7:0];
            srmpu_pkg::OFF_END_HI:   w_rdata = r_end[15:8];
            srmpu_pkg::OFF_PERMS:    w_rdata = r_perms;
            srmpu_pkg::OFF_VADDR_LO: w_rdata = r_vaddr[7:0];
            srmpu_pkg::OFF_VADDR_HI: w_rdata = r_vaddr[15:8];
            srmpu_pkg::OFF_VKIND:    w_rdata = {6'd0, r_vkind};
            default:                 w_rdata = 8'd0;
        endcase
    end

    // next state and result
    always_comb begin
        n_ctrl   = r_ctrl;
        n_start  = r_start;
        n_end    = r_end;
        n_perms  = r_perms;
        n_vaddr  = r_vaddr;
        n_vkind  = r_vkind;
        n_irq    = r_irq;
        o_result = '0;
        case (i_item.action)
            srmpu_pkg::ACT_REG_READ: begin
                o_result.read_data = w_rdata;
            end
            srmpu_pkg::ACT_REG_WRITE: begin
                case (i_item.reg_offset)
                    srmpu_pkg::OFF_CTRL:     n_ctrl  = i_item.write_data;
                    srmpu_pkg::OFF_START_LO: n_start = {r_start[15:8], i_item.write_data};
                    srmpu_pkg::OFF_START_HI: n_start = {i_item.write_data, r_start[7:0]};
                    srmpu_pkg::OFF_END_LO:   n_end   = {r_end[15:8], i_item.write_data};
                    srmpu_pkg::OFF_END_HI:   n_end   = {i_item.write_data, r_end[7:0]};
                    srmpu_pkg::OFF_PERMS:    n_perms = i_item.write_data;
                    srmpu_pkg::OFF_CLEAR: begin
                        n_vkind = srmpu_pkg::FLT_NONE;
                        n_irq   = 1'b0;
                    end
                    default: begin
                        n_ctrl = r_ctrl;
                    end
                endcase
            end
            srmpu_pkg::ACT_CHECK: begin
                o_result.access_ok = 1'b1;
                if (w_win_hit) begin
                    o_result.granted_perms = srmpu_pkg::PR_READ | srmpu_pkg::PR_WRITE;
                    o_result.window_hit    = 1'b1;
                end else if (!w_in_region) begin
                    o_result.granted_perms = srmpu_pkg::PR_ALL;
                end else begin
                    o_result.granted_perms = w_rperms;
                    o_result.fault_kind    = w_fault;
                    if (w_fault != srmpu_pkg::FLT_NONE) begin
                        o_result.access_ok = 1'b0;
                        n_vaddr = i_item.address;
                        n_vkind = w_fault;
                        if (r_ctrl[srmpu_pkg::CTL_IRQ_BIT]) n_irq = 1'b1;
                    end
                end
            end
            default: begin
                o_result.read_data = 8'd0;
            end
        endcase
        o_result.irq_out = n_irq;
    end

    // architectural state, updated once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_perms <= '0;
            r_vaddr <= '0;
            r_vkind <= '0;
            r_irq   <= 1'b0;
        end else if (i_fire) begin
            r_ctrl  <= n_ctrl;
            r_start <= n_start;
            r_end   <= n_end;
            r_perms <= n_perms;
            r_vaddr <= n_vaddr;
            r_vkind <= n_vkind;
            r_irq   <= n_irq;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srmpu_out_stage.sv =====
`default_nettype none

module srmpu_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire srmpu_pkg::t_result i_result,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output srmpu_pkg::t_result      o_result
);

    logic               r_valid;
    srmpu_pkg::t_result r_result;

    // room when empty or when the held result is taken this cycle
    assign o_ready = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== test/single_region_memory_protection_unit_test.sv =====
`timescale 1ns / 100ps

module single_region_memory_protection_unit_test;

    import srmpu_pkg::*;

    // codes that the package leaves unnamed but the fields allow
    localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam int RANDOM_ITEMS_PER_PHASE = 460;
    localparam int HOLD_CYCLES            = 300;
    localparam int WATCHDOG_LIMIT         = 2000;
    localparam int SETTLE_CYCLES          = 8;
    localparam int MAX_REPORTS            = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [3:0] reg_offset, [11:4] write_data, [27:12] address, [31:28] zero
    logic [31:0] s_axis_tdata = '0;
    // [1:0] action, [3:2] access_kind
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] read_data, [8] access_ok, [11:9] granted_perms, [12] window_hit,
    // [13] irq_out, [15:14] zero
    logic [15:0] m_axis_tdata;
    // [1:0] fault_kind
    logic [1:0]  m_axis_tuser;

    single_region_memory_protection_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // stimulus and expected results
    t_item   pending_items[$];
    t_result pending_results[$];
    t_item   offered_item;

    // flow control knobs, written by the sequencer between clock edges
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    // shadow of the mpu registers
    logic [7:0]  mpu_ctrl = '0;
    logic [15:0] mpu_start = '0;
    logic [15:0] mpu_end = '0;
    logic [7:0]  mpu_perms = '0;
    logic [15:0] mpu_vaddr = '0;
    logic [1:0]  mpu_vkind = '0;
    logic        mpu_irq = 1'b0;

    // region bounds as the generator expects them to be
    logic [15:0] gen_start = '0;
    logic [15:0] gen_end = '0;

    int mismatches = 0;
    int results_seen = 0;
    int checks_done = 0;
    int faults_seen = 0;
    int irq_raises = 0;
    int reg_writes = 0;
    int idle_cycles = 0;

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // mpu behavior: result of one item, with the register update it causes
    function automatic t_result predict_result(t_item it);
        t_result    r;
        logic [2:0] perms;
        logic [1:0] fault;
        r = '0;
        case (it.action)
            ACT_REG_READ: begin
                case (it.reg_offset)
                    OFF_CTRL:     r.read_data = mpu_ctrl;
                    OFF_START_LO: r.read_data = mpu_start[7:0];
                    OFF_START_HI: r.read_data = mpu_start[15:8];
                    OFF_END_LO:   r.read_data = mpu_end[7:0];
                    OFF_END_HI:   r.read_data = mpu_end[15:8];
                    OFF_PERMS:    r.read_data = mpu_perms;
                    OFF_VADDR_LO: r.read_data = mpu_vaddr[7:0];
                    OFF_VADDR_HI: r.read_data = mpu_vaddr[15:8];
                    OFF_VKIND:    r.read_data = {6'd0, mpu_vkind};
                    default:      r.read_data = 8'd0;
                endcase
            end
            ACT_REG_WRITE: begin
                reg_writes++;
                case (it.reg_offset)
                    OFF_CTRL:     mpu_ctrl = it.write_data;
                    OFF_START_LO: mpu_start[7:0] = it.write_data;
                    OFF_START_HI: mpu_start[15:8] = it.write_data;
                    OFF_END_LO:   mpu_end[7:0] = it.write_data;
                    OFF_END_HI:   mpu_end[15:8] = it.write_data;
                    OFF_PERMS:    mpu_perms = it.write_data;
                    OFF_CLEAR: begin
                        mpu_vkind = FLT_NONE;
                        mpu_irq = 1'b0;
                    end
                    default: ;
                endcase
            end
            ACT_CHECK: begin
                checks_done++;
                r.access_ok = 1'b1;
                fault = FLT_NONE;
                if (it.address >= WIN_BASE && it.address <= WIN_LAST) begin
                    r.granted_perms = PR_READ | PR_WRITE;
                    r.window_hit = 1'b1;
                end else if (!mpu_ctrl[CTL_EN_BIT] || it.address < mpu_start ||
                             it.address > mpu_end) begin
                    r.granted_perms = PR_ALL;
                end else begin
                    perms = mpu_perms[2:0];
                    r.granted_perms = perms;
                    if (it.access_kind == KIND_FETCH && (perms & PR_EXEC) == 3'd0)
                        fault = FLT_FETCH;
                    else if (it.access_kind == KIND_READ && (perms & PR_READ) == 3'd0)
                        fault = FLT_READ;
                    else if (it.access_kind == KIND_WRITE && (perms & PR_WRITE) == 3'd0)
                        fault = FLT_WRITE;
                    if (fault != FLT_NONE) begin
                        faults_seen++;
                        r.access_ok = 1'b0;
                        mpu_vaddr = it.address;
                        mpu_vkind = fault;
                        if (mpu_ctrl[CTL_IRQ_BIT]) begin
                            if (!mpu_irq)
                                irq_raises++;
                            mpu_irq = 1'b1;
                        end
                    end
                end
                r.fault_kind = fault;
            end
            default: ;
        endcase
        r.irq_out = mpu_irq;
        return r;
    endfunction

    function automatic t_item mk(logic [1:0] act, logic [3:0] off, logic [7:0] data,
                                 logic [15:0] addr, logic [1:0] kind);
        t_item it;
        it.action = act;
        it.reg_offset = off;
        it.write_data = data;
        it.address = addr;
        it.access_kind = kind;
        return it;
    endfunction

    // queue an item and follow the region bounds it sets
    task automatic queue_item(t_item it);
        if (it.action == ACT_REG_WRITE) begin
            case (it.reg_offset)
                OFF_START_LO: gen_start[7:0] = it.write_data;
                OFF_START_HI: gen_start[15:8] = it.write_data;
                OFF_END_LO:   gen_end[7:0] = it.write_data;
                OFF_END_HI:   gen_end[15:8] = it.write_data;
                default: ;
            endcase
        end
        pending_items.push_back(it);
    endtask

    // mostly well-formed register programming and checks around the region
    function automatic t_item make_random_item();
        t_item       it;
        int unsigned pick;
        int unsigned sel;
        it.reg_offset = 4'($urandom);
        it.write_data = 8'($urandom);
        it.address = 16'($urandom);
        it.access_kind = ($urandom_range(19) == 0) ? KIND_UNKNOWN : 2'($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 4) begin
            it.action = ACT_UNKNOWN;
        end else if (pick < 16) begin
            it.action = ACT_REG_READ;
        end else if (pick < 38) begin
            it.action = ACT_REG_WRITE;
            sel = $urandom_range(99);
            if (sel < 12) begin
                it.reg_offset = OFF_CTRL;
                if ($urandom_range(4) != 0)
                    it.write_data[CTL_EN_BIT] = 1'b1;
            end else if (sel < 24) begin
                it.reg_offset = OFF_START_LO;
            end else if (sel < 36) begin
                it.reg_offset = OFF_START_HI;
            end else if (sel < 48) begin
                it.reg_offset = OFF_END_LO;
            end else if (sel < 60) begin
                it.reg_offset = OFF_END_HI;
                // keep the region a sane size most of the time
                if ($urandom_range(4) != 0)
                    it.write_data = gen_start[15:8] + 8'($urandom_range(3));
            end else if (sel < 75) begin
                it.reg_offset = OFF_PERMS;
            end else if (sel < 87) begin
                it.reg_offset = OFF_CLEAR;
            end
        end else begin
            it.action = ACT_CHECK;
            sel = $urandom_range(9);
            case (sel)
                0: it.address = gen_start;
                1: it.address = gen_start - 16'd1;
                2: it.address = gen_end;
                3: it.address = gen_end + 16'd1;
                4, 5, 6: begin
                    if (gen_start <= gen_end)
                        it.address = 16'($urandom_range(gen_end, gen_start));
                end
                7: it.address = WIN_BASE - 16'd8 + 16'($urandom_range(31));
                default: ;
            endcase
        end
        return it;
    endfunction

    // sender: hold the offered item until its transfer, then offer the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_result(offered_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'd0, offered_item.address, offered_item.write_data,
                                     offered_item.reg_offset};
                    s_axis_tuser <= {offered_item.access_kind, offered_item.action};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.read_data = m_axis_tdata[7:0];
                got.access_ok = m_axis_tdata[8];
                got.granted_perms = m_axis_tdata[11:9];
                got.window_hit = m_axis_tdata[12];
                got.irq_out = m_axis_tdata[13];
                got.fault_kind = m_axis_tuser;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing expected: tdata %h tuser %h",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_data !== want.read_data ||
                        got.access_ok !== want.access_ok ||
                        got.fault_kind !== want.fault_kind ||
                        got.granted_perms !== want.granted_perms ||
                        got.window_hit !== want.window_hit ||
                        got.irq_out !== want.irq_out) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  expected rd %h ok %b fault %0d perms %b win %b irq %b",
                                     want.read_data, want.access_ok, want.fault_kind,
                                     want.granted_perms, want.window_hit, want.irq_out);
                            $display("  got      rd %h ok %b fault %0d perms %b win %b irq %b",
                                     got.read_data, got.access_ok, got.fault_kind,
                                     got.granted_perms, got.window_hit, got.irq_out);
                        end
                    end
                end
            end
            // long back-pressure on request, otherwise random stalls
            if (hold_trigger != hold_seen) begin
                hold_seen <= hold_trigger;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $realtime, idle_cycles, pending_results.size());
            $display("single_region_memory_protection_unit_test failed");
            $finish;
        end
    end

    // sender pause until every expected result has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // sequencer
    initial begin
        int unsigned phase_send[4];
        int unsigned phase_recv[4];
        phase_send = '{0, 62, 0, 32};
        phase_recv = '{0, 0, 62, 32};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset values, window edges, disabled unit
        queue_item(mk(ACT_REG_READ, OFF_CTRL, 8'hFF, 16'hFFFF, KIND_READ));
        queue_item(mk(ACT_REG_READ, 4'd15, 8'h00, 16'h0000, KIND_UNKNOWN));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h1234, KIND_FETCH));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, WIN_BASE, KIND_FETCH));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, WIN_LAST, KIND_WRITE));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, WIN_BASE - 16'd1, KIND_READ));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, WIN_LAST + 16'd1, KIND_READ));
        // region 0x1000..0x1fff with no permissions, upper perm bits set
        queue_item(mk(ACT_REG_WRITE, OFF_START_LO, 8'h00, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_START_HI, 8'h10, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_END_LO, 8'hFF, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_END_HI, 8'h1F, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_PERMS, 8'hF8, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_CTRL, 8'h03, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_READ, OFF_PERMS, 8'h00, 16'h0000, KIND_READ));
        // every fault kind, unknown kind, just below the region
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h1000, KIND_READ));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h1FFF, KIND_WRITE));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h1800, KIND_FETCH));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h1800, KIND_UNKNOWN));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h0FFF, KIND_READ));
        queue_item(mk(ACT_REG_READ, OFF_VADDR_LO, 8'h00, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_READ, OFF_VADDR_HI, 8'h00, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_READ, OFF_VKIND, 8'h00, 16'h0000, KIND_READ));
        // clear keeps the address, then a fault with the interrupt disabled
        queue_item(mk(ACT_REG_WRITE, OFF_CLEAR, 8'hFF, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_READ, OFF_VADDR_HI, 8'h00, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_CTRL, 8'h01, 16'h0000, KIND_READ));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h1000, KIND_READ));
        queue_item(mk(ACT_REG_READ, OFF_VKIND, 8'h00, 16'h0000, KIND_READ));
        // ignored writes, unknown action, empty region
        queue_item(mk(ACT_REG_WRITE, 4'd7, 8'hAA, 16'h0000, KIND_READ));
        queue_item(mk(ACT_REG_WRITE, OFF_VKIND, 8'h03, 16'h0000, KIND_READ));
        queue_item(mk(ACT_UNKNOWN, 4'hF, 8'hFF, 16'hFFFF, KIND_UNKNOWN));
        queue_item(mk(ACT_REG_WRITE, OFF_START_HI, 8'h20, 16'h0000, KIND_READ));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h2000, KIND_FETCH));
        queue_item(mk(ACT_CHECK, OFF_CTRL, 8'h00, 16'h0000, KIND_WRITE));
        wait_drained();

        // random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++)
                queue_item(make_random_item());
            // receiver holds off while the sender keeps offering
            if (ph == 0)
                hold_trigger = ~hold_trigger;
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0)
            mismatches++;

        $display("covered %0d results: %0d access checks, %0d faults, %0d irq raises,",
                 results_seen, checks_done, faults_seen, irq_raises);
        $display("%0d register writes, four idling mixes and one long receiver hold-off",
                 reg_writes);
        if (mismatches == 0) begin
            $display("single_region_memory_protection_unit_test passed");
        end else begin
            $display("single_region_memory_protection_unit_test failed");
        end
        $finish;
    end

endmodule
